[rtl/core/sorted_priority_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue unit
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq: same-cycle check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq: next-cycle check failed");

`endif

[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Command and status codes, FSM states and the cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_e;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // shift back from the insertion point
    logic del;  // shift forward from the first match
    logic rot;  // rotate occupied cells toward the head
  } cell_ctrl_t;

endpackage

[rtl/core/spq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq command and result channels
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface spq_cmd_if
  import spq_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic        [CMD_W-1:0]       command;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface spq_res_if
  import spq_pkg::*;
#(
  parameter int VALUE_WIDTH = 16,
  parameter int OCC_WIDTH   = 4
) ();
  logic                          valid;
  logic                          ready;
  logic        [STAT_W-1:0]      status;
  logic signed [VALUE_WIDTH-1:0] entry_value;
  logic                          last;
  logic        [OCC_WIDTH-1:0]   occupancy;

  modport source (output valid, status, entry_value, last, occupancy, input ready);
  modport sink   (input valid, status, entry_value, last, occupancy, output ready);
endinterface

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value and an occupied flag and
// trades data with its left and right neighbors.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic signed [VALUE_WIDTH-1:0] head_i,
  input  logic signed [VALUE_WIDTH-1:0] left_val_i,
  input  logic                          left_occ_i,
  input  logic                          left_take_i,
  input  logic                          left_found_i,
  input  logic signed [VALUE_WIDTH-1:0] right_val_i,
  input  logic                          right_occ_i,
  output logic signed [VALUE_WIDTH-1:0] val_o,
  output logic                          occ_o,
  output logic                          take_o,
  output logic                          found_o
);

  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic                          occ_q, occ_d;

  // Key lands here or further left: slot is free or key >= stored value.
  assign take_o  = !occ_q || (key_i >= val_q);
  // First match so far along the chain, this slot included.
  assign found_o = left_found_i || (occ_q && (key_i == val_q));
  assign val_o   = val_q;
  assign occ_o   = occ_q;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (ctrl_i.ins && take_o) begin
      val_d = left_take_i ? left_val_i : key_i;
      occ_d = occ_q || left_occ_i;
    end else if (ctrl_i.del && found_o) begin
      val_d = right_val_i;
      occ_d = right_occ_i;
    end else if (ctrl_i.rot && occ_q) begin
      val_d = right_occ_i ? right_val_i : head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[rtl/core/sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Shift-register priority queue holding up to DEPTH signed values in
// descending order, with insert, delete and list commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command per transfer: insert a value, delete the first
//   equal value, or list all entries. out_o carries results (status, listed
//   entry, last flag, occupancy after the command).
//   Insert and delete each give a single result: the chain updates in the
//   transfer cycle and the result sits in the output register the cycle after.
//   A new command is taken every cycle while no list is running and the
//   result register is free or being drained in the same cycle.
//   A list of N entries emits N results, head first: the chain rotates by one
//   cell per emitted result and is back in its original order after the
//   last one. in_i stays not-ready until the last listed entry is loaded.
//   Reset empties the queue (occupancy flags and fill count cleared).
//   When the receiver stalls, the result register holds its contents and the
//   input side stalls with it; nothing is dropped.
//   Command code 3 is taken and ignored.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH       = 8,
  parameter int VALUE_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_cmd_if.sink   in_i,
  spq_res_if.source out_o
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  // Chain wiring: one entry per cell, read only at fixed places.
  logic signed [VALUE_WIDTH-1:0] cell_val   [DEPTH];
  logic                          cell_occ   [DEPTH];
  logic                          cell_take  [DEPTH];
  logic                          cell_found [DEPTH];

  cell_ctrl_t ctrl;

  state_e state_q, state_d;
  logic [OCC_W-1:0] fill_q, fill_d;
  logic [OCC_W-1:0] list_cnt_q, list_cnt_d;

  // Result register.
  logic                          res_valid_q, res_valid_d;
  logic        [STAT_W-1:0]      res_status_q, res_status_d;
  logic signed [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  logic                          res_last_q, res_last_d;
  logic        [OCC_W-1:0]       res_occ_q, res_occ_d;
  logic                          res_load;

  logic out_free;
  logic in_fire;
  logic q_full;
  logic q_empty;

  // Chain of cells: cell 0 holds the largest value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .key_i        (in_i.value),
        .head_i       (cell_val[0]),
        .left_val_i   (in_i.value),
        .left_occ_i   (1'b1),
        .left_take_i  (1'b0),
        .left_found_i (1'b0),
        .right_val_i  (cell_val[(DEPTH > 1) ? 1 : 0]),
        .right_occ_i  (cell_occ[(DEPTH > 1) ? 1 : 0] && (DEPTH > 1)),
        .val_o        (cell_val[0]),
        .occ_o        (cell_occ[0]),
        .take_o       (cell_take[0]),
        .found_o      (cell_found[0])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .key_i        (in_i.value),
        .head_i       (cell_val[0]),
        .left_val_i   (cell_val[i-1]),
        .left_occ_i   (cell_occ[i-1]),
        .left_take_i  (cell_take[i-1]),
        .left_found_i (cell_found[i-1]),
        .right_val_i  (cell_val[0]),
        .right_occ_i  (1'b0),
        .val_o        (cell_val[i]),
        .occ_o        (cell_occ[i]),
        .take_o       (cell_take[i]),
        .found_o      (cell_found[i])
      );
    end else begin : g_mid
      spq_cell #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .key_i        (in_i.value),
        .head_i       (cell_val[0]),
        .left_val_i   (cell_val[i-1]),
        .left_occ_i   (cell_occ[i-1]),
        .left_take_i  (cell_take[i-1]),
        .left_found_i (cell_found[i-1]),
        .right_val_i  (cell_val[i+1]),
        .right_occ_i  (cell_occ[i+1]),
        .val_o        (cell_val[i]),
        .occ_o        (cell_occ[i]),
        .take_o       (cell_take[i]),
        .found_o      (cell_found[i])
      );
    end
  end

  // Result slot is free if empty or drained this cycle.
  assign out_free   = !res_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign q_full     = (fill_q == OCC_W'(DEPTH));
  assign q_empty    = (fill_q == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (cmd_e'(in_i.command) == CMD_LIST) && !q_empty) begin
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        if (out_free && (list_cnt_q == OCC_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chain control, counters and result loading.
  always_comb begin
    ctrl         = '0;
    fill_d       = fill_q;
    list_cnt_d   = list_cnt_q;
    res_load     = 1'b0;
    res_status_d = STAT_OK;
    res_value_d  = '0;
    res_last_d   = 1'b1;
    res_occ_d    = fill_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e'(in_i.command))
            CMD_INSERT: begin
              res_load = 1'b1;
              if (q_full) begin
                res_status_d = STAT_OVERFLOW;
              end else begin
                ctrl.ins  = 1'b1;
                fill_d    = fill_q + OCC_W'(1);
                res_occ_d = fill_d;
              end
            end
            CMD_DELETE: begin
              res_load = 1'b1;
              if (q_empty) begin
                res_status_d = STAT_EMPTY;
              end else if (!cell_found[DEPTH-1]) begin
                res_status_d = STAT_NOT_FOUND;
              end else begin
                ctrl.del  = 1'b1;
                fill_d    = fill_q - OCC_W'(1);
                res_occ_d = fill_d;
              end
            end
            CMD_LIST: begin
              if (q_empty) begin
                res_load     = 1'b1;
                res_status_d = STAT_EMPTY;
              end else begin
                list_cnt_d = fill_q;
              end
            end
            default: begin
              // unused code: drop silently
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          // Emit the head, then rotate the next entry into cell 0.
          res_load    = 1'b1;
          res_value_d = cell_val[0];
          res_last_d  = (list_cnt_q == OCC_W'(1));
          ctrl.rot    = 1'b1;
          list_cnt_d  = list_cnt_q - OCC_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (out_free) begin
      res_valid_d = res_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      list_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      list_cnt_q  <= list_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload: load only with a new result, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_last_q   <= res_last_d;
      res_occ_q    <= res_occ_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.entry_value = res_value_q;
  assign out_o.last        = res_last_q;
  assign out_o.occupancy   = res_occ_q;

endmodule

[rtl/core/spq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue unit, bound to the top.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH       = 8,
  parameter int VALUE_WIDTH = 16,
  parameter int OCC_W       = 4
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic        [STAT_W-1:0]      status_i,
  input logic signed [VALUE_WIDTH-1:0] entry_value_i,
  input logic                          last_i,
  input logic        [OCC_W-1:0]       occupancy_i
);

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;

  // Stalled result holds.
  `SPQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(entry_value_i) && $stable(status_i) && $stable(last_i))

  // No new command while a result is stuck.
  `SPQ_ASSERT_IMP(a_in_stall, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

  // Error results are single and carry no entry.
  `SPQ_ASSERT_IMP(a_err_last, clk_i, rst_ni, out_valid_i && (status_i != STAT_OK), last_i && (entry_value_i == '0))

  // Occupancy never exceeds the chain length.
  `SPQ_ASSERT_IMP(a_occ_max, clk_i, rst_ni, out_valid_i, occupancy_i <= OCC_W'(DEPTH))

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH),
  .OCC_W       (OCC_W)
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .entry_value_i (out_o.entry_value),
  .last_i        (out_o.last),
  .occupancy_i   (out_o.occupancy)
);
